>>> src/plsu_pkg.sv
package plsu_pkg;

    // Operation codes of the kind field
    typedef enum logic [3:0] {
        K_AND  = 4'd0,
        K_ANDN = 4'd1,
        K_OR   = 4'd2,
        K_XOR  = 4'd3,
        K_SRLW = 4'd4,
        K_SRAW = 4'd5,
        K_SLLW = 4'd6,
        K_SRLD = 4'd7,
        K_SRAD = 4'd8,
        K_SLLD = 4'd9,
        K_SRLQ = 4'd10,
        K_SLLQ = 4'd11
    } t_kind;

    // Lane size of a shift
    typedef enum logic [1:0] {
        LSZ_16 = 2'd0,
        LSZ_32 = 2'd1,
        LSZ_64 = 2'd2
    } t_lsz;

    typedef struct packed {
        logic [3:0]  kind;
        logic        wide;
        logic [63:0] dst_lo;
        logic [63:0] dst_hi;
        logic [63:0] src_lo;
        logic [63:0] src_hi;
        logic [31:0] shift_count;
    } t_in_item;

    typedef struct packed {
        logic [63:0] res_lo;
        logic [63:0] res_hi;
    } t_out_item;

    // One pipeline slot: data to shift right per lane, fill bits per position
    typedef struct packed {
        logic        valid;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] fill_lo;
        logic [63:0] fill_hi;
        logic [5:0]  amt;
        t_lsz        lsz;
        logic        rev;
    } t_stage;

    // Lane width minus one
    function automatic logic [5:0] lane_msb(input t_lsz lsz);
        logic [5:0] m;
        case (lsz)
            LSZ_16:  m = 6'd15;
            LSZ_32:  m = 6'd31;
            LSZ_64:  m = 6'd63;
            default: m = 6'd63;
        endcase
        return m;
    endfunction

    // Shift each lane right by amt, pulling fill bits in at the lane top
    function automatic logic [63:0] shr_lanes(input logic [63:0] x, input logic [63:0] fill,
                                              input t_lsz lsz, input logic [5:0] amt);
        logic [63:0] r;
        logic [5:0]  wm;
        logic [6:0]  pos;
        logic [6:0]  src;
        wm = lane_msb(lsz);
        for (int i = 0; i < 64; i++) begin
            pos = {1'b0, 6'(i) & wm} + {1'b0, amt};
            src = 7'(i) + {1'b0, amt};
            if (pos <= {1'b0, wm}) begin
                r[i] = x[src[5:0]];
            end else begin
                r[i] = fill[i];
            end
        end
        return r;
    endfunction

    // Bit-reverse a half; lanes are symmetric so a per-lane left shift
    // becomes a per-lane right shift of the reversed word
    function automatic logic [63:0] rev64(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) begin
            r[i] = x[63 - i];
        end
        return r;
    endfunction

endpackage

>>> src/plsu_shr_stage.sv
module plsu_shr_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plsu_pkg::t_stage i_stage,
    input  logic [5:0]      i_amt,
    output plsu_pkg::t_stage o_stage
);
    import plsu_pkg::*;

    t_stage r_stage;
    t_stage n_stage;

    // Shift both halves by this step's part of the count
    always_comb begin
        n_stage    = i_stage;
        n_stage.lo = shr_lanes(i_stage.lo, i_stage.fill_lo, i_stage.lsz, i_amt);
        n_stage.hi = shr_lanes(i_stage.hi, i_stage.fill_hi, i_stage.lsz, i_amt);
    end

    // Advance every cycle; clear the slot on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> src/packed_integer_logic_shift_unit_top.sv
// Packed integer logic and shift unit (MMX/SSE2 style). One item may start in
// every cycle and its result appears with o_valid after passing through the
// registered steps: decode and logic ops, a coarse per-lane shift by
// multiples of eight, a fine shift of zero to seven, and the output register.
// o_busy is always low because the pipeline never stalls; the receiver must
// take each result in the single cycle that o_valid marks it.
module packed_integer_logic_shift_unit_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  plsu_pkg::t_in_item  i_item,
    output logic                o_busy,
    output logic                o_valid,
    output plsu_pkg::t_out_item o_res
);
    import plsu_pkg::*;

    t_stage    r_s1;
    t_stage    n_s1;
    t_stage    w_s2;
    t_stage    w_s3;
    t_out_item r_res;
    t_out_item n_res;
    logic      r_valid;

    logic        is_shift;
    logic        is_sra;
    logic        is_left;
    t_lsz        lsz;
    logic [5:0]  wm;
    logic        over;
    logic [63:0] lg_lo;
    logic [63:0] lg_hi;
    logic [5:0]  mi;

    // Decode the item, do logic ops, and line up shift operands
    always_comb begin
        is_shift = 1'b1;
        is_sra   = 1'b0;
        is_left  = 1'b0;
        lsz      = LSZ_64;
        lg_lo    = i_item.dst_lo;
        lg_hi    = i_item.dst_hi;
        mi       = '0;
        case (t_kind'(i_item.kind))
            K_AND: begin
                is_shift = 1'b0;
                lg_lo = i_item.src_lo & i_item.dst_lo;
                lg_hi = i_item.src_hi & i_item.dst_hi;
            end
            K_ANDN: begin
                is_shift = 1'b0;
                lg_lo = i_item.src_lo & ~i_item.dst_lo;
                lg_hi = i_item.src_hi & ~i_item.dst_hi;
            end
            K_OR: begin
                is_shift = 1'b0;
                lg_lo = i_item.src_lo | i_item.dst_lo;
                lg_hi = i_item.src_hi | i_item.dst_hi;
            end
            K_XOR: begin
                is_shift = 1'b0;
                lg_lo = i_item.src_lo ^ i_item.dst_lo;
                lg_hi = i_item.src_hi ^ i_item.dst_hi;
            end
            K_SRLW: lsz = LSZ_16;
            K_SRAW: begin
                lsz    = LSZ_16;
                is_sra = 1'b1;
            end
            K_SLLW: begin
                lsz     = LSZ_16;
                is_left = 1'b1;
            end
            K_SRLD: lsz = LSZ_32;
            K_SRAD: begin
                lsz    = LSZ_32;
                is_sra = 1'b1;
            end
            K_SLLD: begin
                lsz     = LSZ_32;
                is_left = 1'b1;
            end
            K_SRLQ: lsz = LSZ_64;
            K_SLLQ: begin
                lsz     = LSZ_64;
                is_left = 1'b1;
            end
            default: is_shift = 1'b0;
        endcase

        wm   = lane_msb(lsz);
        over = i_item.shift_count > {26'd0, wm};

        n_s1.valid   = i_start;
        n_s1.lsz     = lsz;
        n_s1.rev     = is_left;
        n_s1.fill_lo = '0;
        n_s1.fill_hi = '0;
        n_s1.lo      = lg_lo;
        n_s1.hi      = lg_hi;
        n_s1.amt     = '0;

        if (is_shift) begin
            // Logical shifts past the lane clear it; arithmetic ones clamp
            if (is_sra) begin
                n_s1.amt = over ? wm : i_item.shift_count[5:0];
                for (int i = 0; i < 64; i++) begin
                    mi = 6'(i) | wm;
                    n_s1.fill_lo[i] = i_item.dst_lo[mi];
                    n_s1.fill_hi[i] = i_item.dst_hi[mi];
                end
            end else if (!over) begin
                n_s1.amt = i_item.shift_count[5:0];
            end
            if (is_left) begin
                n_s1.lo = rev64(i_item.dst_lo);
                n_s1.hi = rev64(i_item.dst_hi);
            end else begin
                n_s1.lo = i_item.dst_lo;
                n_s1.hi = i_item.dst_hi;
            end
            if (over && !is_sra) begin
                n_s1.lo = '0;
                n_s1.hi = '0;
            end
        end

        // Narrow operand: high half is zero all the way through
        if (!i_item.wide) begin
            n_s1.hi      = '0;
            n_s1.fill_hi = '0;
        end
    end

    // Hold stage one; clear it on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    // Coarse step: multiples of eight
    plsu_shr_stage u_coarse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (r_s1),
        .i_amt   ({r_s1.amt[5:3], 3'd0}),
        .o_stage (w_s2)
    );

    // Fine step: zero to seven
    plsu_shr_stage u_fine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_s2),
        .i_amt   ({3'd0, w_s2.amt[2:0]}),
        .o_stage (w_s3)
    );

    // Undo the reversal of left shifts
    always_comb begin
        n_res.res_lo = w_s3.rev ? rev64(w_s3.lo) : w_s3.lo;
        n_res.res_hi = w_s3.rev ? rev64(w_s3.hi) : w_s3.hi;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_s3.valid;
        end
    end

    assign o_busy  = 1'b0;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> src/plsu_checker.sv
module plsu_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input plsu_pkg::t_in_item  i_item,
    input logic                o_busy,
    input logic                o_valid,
    input plsu_pkg::t_out_item o_res
);
    import plsu_pkg::*;

    // Each accepted item yields its result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##4 o_valid)
        else $error("accepted item produced no result");

    // No result without an earlier accepted item
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 4))
        else $error("result without an item");

    // Narrow items give a zero high half
    a_narrow_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(i_item.wide, 4)) |-> (o_res.res_hi == 64'd0))
        else $error("narrow item has nonzero high half");

    // The low half of AND results matches the operands
    a_and: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_item.kind, 4) == K_AND) |->
            (o_res.res_lo == $past(i_item.src_lo & i_item.dst_lo, 4)))
        else $error("AND result mismatch");

endmodule

bind packed_integer_logic_shift_unit_top plsu_checker u_plsu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_item  (i_item),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);
